>>> src/stunp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the stun binding response parser
// no dependencies

package stunp_pkg;

    localparam int unsigned HDR_BYTES = 20;

    localparam logic [31:0] COOKIE_WORD  = 32'h2112_A442;
    localparam logic [15:0] TYPE_SUCCESS = 16'h0101;
    localparam logic [15:0] TYPE_ERROR   = 16'h0111;
    localparam logic [15:0] ATTR_XOR     = 16'h0020;
    localparam logic [15:0] ATTR_LEGACY  = 16'h0001;
    localparam logic [7:0]  FAMILY_V4    = 8'h01;
    localparam logic [7:0]  TOP_BITS     = 8'hC0;

    localparam logic CFG_TXN_HIGH = 1'b0;
    localparam logic CFG_TXN_LOW  = 1'b1;

    localparam logic [1:0] VERDICT_NONE    = 2'd0;
    localparam logic [1:0] VERDICT_SUCCESS = 2'd1;
    localparam logic [1:0] VERDICT_ERROR   = 2'd2;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_XOR    = 2'd1;
    localparam logic [1:0] KIND_LEGACY = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_beat;

    typedef struct packed {
        logic [31:0] mapped_address;
        logic [1:0]  address_kind;
        logic [1:0]  verdict;
    } t_result;

endpackage

>>> src/stunp_parse.sv
`timescale 1ns / 1ps
// per-byte header check and attribute walk, one beat per cycle while i_go is high
// depends on stunp_pkg

module stunp_parse #(
    parameter int unsigned MAX_DATAGRAM_BYTES = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [63:0]      i_cfg_wdata,
    input  logic             i_go,
    input  stunp_pkg::t_beat i_beat,
    output logic             o_res_valid,
    output stunp_pkg::t_result o_res
);
    import stunp_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_DATAGRAM_BYTES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DATAGRAM_BYTES);

    logic [31:0]      r_txn_high;
    logic [63:0]      r_txn_low;
    logic [CNT_W-1:0] r_count,       n_count;
    logic [15:0]      r_msg_type,    n_msg_type;
    logic [15:0]      r_body_len,    n_body_len;
    logic             r_hdr_good,    n_hdr_good;
    logic [16:0]      r_next_attr,   n_next_attr;
    logic [15:0]      r_attr_kind,   n_attr_kind;
    logic [15:0]      r_attr_len,    n_attr_len;
    logic [7:0]       r_attr_family, n_attr_family;
    logic             r_walk_stop,   n_walk_stop;
    logic [31:0]      r_xor_addr,    n_xor_addr;
    logic             r_xor_found,   n_xor_found;
    logic [31:0]      r_leg_addr,    n_leg_addr;
    logic             r_leg_found,   n_leg_found;

    logic [7:0]  b;
    logic [4:0]  hp;
    logic [95:0] txn_id;
    logic [7:0]  want;
    logic [17:0] pe, o, rel, span, lim;
    logic        fits;
    logic        ok;

    assign b      = i_beat.data_byte;
    assign txn_id = {r_txn_high, r_txn_low};

    always_comb begin
        n_count       = r_count;
        n_msg_type    = r_msg_type;
        n_body_len    = r_body_len;
        n_hdr_good    = r_hdr_good;
        n_next_attr   = r_next_attr;
        n_attr_kind   = r_attr_kind;
        n_attr_len    = r_attr_len;
        n_attr_family = r_attr_family;
        n_walk_stop   = r_walk_stop;
        n_xor_addr    = r_xor_addr;
        n_xor_found   = r_xor_found;
        n_leg_addr    = r_leg_addr;
        n_leg_found   = r_leg_found;
        hp   = r_count[4:0];
        want = 8'h00;
        pe   = 18'(r_count);
        lim  = 18'(HDR_BYTES) + 18'(r_body_len);
        o    = 18'(r_next_attr);
        rel  = 18'd0;
        span = 18'd0;
        fits = 1'b0;
        if (r_count < MAX_CNT) begin
            n_count = r_count + 1'b1;
            if (pe < 18'(HDR_BYTES)) begin
                // header bytes
                if (hp == 5'd0) begin
                    if ((b & TOP_BITS) != 8'h00) n_hdr_good = 1'b0;
                    n_msg_type = {b, 8'h00};
                end else if (hp == 5'd1) begin
                    n_msg_type = r_msg_type | {8'h00, b};
                end else if (hp == 5'd2) begin
                    n_body_len = {b, 8'h00};
                end else if (hp == 5'd3) begin
                    n_body_len = r_body_len | {8'h00, b};
                end else begin
                    if (hp < 5'd8) begin
                        want = 8'(COOKIE_WORD >> {5'd7 - hp, 3'b000});
                    end else begin
                        want = 8'(txn_id >> {5'd19 - hp, 3'b000});
                    end
                    if (b != want) n_hdr_good = 1'b0;
                end
            end else if (!r_walk_stop && pe >= o) begin
                // attribute walk
                rel = pe - o;
                if (rel >= 18'd4) begin
                    span = 18'd4 + ((18'(r_attr_len) + 18'd3) & ~18'd3);
                    if (rel == span) begin
                        o           = o + span;
                        n_next_attr = 17'(o);
                        rel         = 18'd0;
                    end
                end
                fits = (r_attr_len >= 16'd8) && (r_attr_family == FAMILY_V4);
                case (rel)
                    18'd0: begin
                        if (o + 18'd4 > lim) begin
                            n_walk_stop = 1'b1;
                        end else begin
                            n_attr_kind   = {b, 8'h00};
                            n_attr_len    = 16'h0000;
                            n_attr_family = 8'h00;
                        end
                    end
                    18'd1: n_attr_kind = r_attr_kind | {8'h00, b};
                    18'd2: n_attr_len  = {b, 8'h00};
                    18'd3: begin
                        n_attr_len = r_attr_len | {8'h00, b};
                        if (o + 18'd4 + 18'(n_attr_len) > lim) n_walk_stop = 1'b1;
                    end
                    18'd5: n_attr_family = b;
                    18'd8, 18'd9, 18'd10, 18'd11: begin
                        if (fits && r_attr_kind == ATTR_XOR && !r_xor_found) begin
                            n_xor_addr = {r_xor_addr[23:0], b};
                            if (rel == 18'd11) begin
                                n_xor_addr  = {r_xor_addr[23:0], b} ^ COOKIE_WORD;
                                n_xor_found = 1'b1;
                            end
                        end
                        if (fits && r_attr_kind == ATTR_LEGACY && !r_leg_found) begin
                            n_leg_addr = {r_leg_addr[23:0], b};
                            if (rel == 18'd11) n_leg_found = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // verdict from the state after this beat
    always_comb begin
        ok = (18'(n_count) >= 18'(HDR_BYTES)) && n_hdr_good &&
             (n_body_len[1:0] == 2'b00) &&
             (18'(n_body_len) <= 18'(n_count) - 18'(HDR_BYTES));
        o_res.verdict        = VERDICT_NONE;
        o_res.address_kind   = KIND_NONE;
        o_res.mapped_address = 32'h0;
        if (ok && n_msg_type == TYPE_ERROR) begin
            o_res.verdict = VERDICT_ERROR;
        end else if (ok && n_msg_type == TYPE_SUCCESS) begin
            o_res.verdict = VERDICT_SUCCESS;
            if (n_xor_found) begin
                o_res.address_kind   = KIND_XOR;
                o_res.mapped_address = n_xor_addr;
            end else if (n_leg_found) begin
                o_res.address_kind   = KIND_LEGACY;
                o_res.mapped_address = n_leg_addr;
            end
        end
    end

    assign o_res_valid = i_go && i_beat.last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_txn_high    <= 32'h0;
            r_txn_low     <= 64'h0;
            r_count       <= '0;
            r_msg_type    <= 16'h0;
            r_body_len    <= 16'h0;
            r_hdr_good    <= 1'b1;
            r_next_attr   <= 17'(HDR_BYTES);
            r_attr_kind   <= 16'h0;
            r_attr_len    <= 16'h0;
            r_attr_family <= 8'h0;
            r_walk_stop   <= 1'b0;
            r_xor_addr    <= 32'h0;
            r_xor_found   <= 1'b0;
            r_leg_addr    <= 32'h0;
            r_leg_found   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_TXN_HIGH: r_txn_high <= i_cfg_wdata[31:0];
                    CFG_TXN_LOW:  r_txn_low  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_go) begin
                if (i_beat.last_byte) begin
                    // clear for the next datagram
                    r_count       <= '0;
                    r_msg_type    <= 16'h0;
                    r_body_len    <= 16'h0;
                    r_hdr_good    <= 1'b1;
                    r_next_attr   <= 17'(HDR_BYTES);
                    r_attr_kind   <= 16'h0;
                    r_attr_len    <= 16'h0;
                    r_attr_family <= 8'h0;
                    r_walk_stop   <= 1'b0;
                    r_xor_addr    <= 32'h0;
                    r_xor_found   <= 1'b0;
                    r_leg_addr    <= 32'h0;
                    r_leg_found   <= 1'b0;
                end else begin
                    r_count       <= n_count;
                    r_msg_type    <= n_msg_type;
                    r_body_len    <= n_body_len;
                    r_hdr_good    <= n_hdr_good;
                    r_next_attr   <= n_next_attr;
                    r_attr_kind   <= n_attr_kind;
                    r_attr_len    <= n_attr_len;
                    r_attr_family <= n_attr_family;
                    r_walk_stop   <= n_walk_stop;
                    r_xor_addr    <= n_xor_addr;
                    r_xor_found   <= n_xor_found;
                    r_leg_addr    <= n_leg_addr;
                    r_leg_found   <= n_leg_found;
                end
            end
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_beat.last_byte) |=> (r_count == '0 && r_hdr_good))
        else $error("state not cleared after final beat");

    a_attr_start_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_attr >= 17'(HDR_BYTES))
        else $error("attribute start inside header");

    a_no_addr_unless_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.verdict != VERDICT_SUCCESS) |->
        (o_res.address_kind == KIND_NONE && o_res.mapped_address == 32'h0))
        else $error("address reported without success");

endmodule

>>> src/stunp_out.sv
`timescale 1ns / 1ps
// result register in front of the master-side stream
// depends on stunp_pkg

module stunp_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_valid,
    input  stunp_pkg::t_result i_res,
    output logic               o_free,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // verdict [1:0], address_kind [3:2], mapped_address [35:4], zero fill [39:36]
    output logic [39:0]        m_axis_tdata
);
    import stunp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free        = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {4'h0, r_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

>>> src/stun_binding_response_parser_core.sv
`timescale 1ns / 1ps
// top level of the stun binding response parser
// depends on stunp_pkg, stunp_parse, stunp_out

// usage
// slave stream: one datagram byte per beat in s_axis_tdata[7:0], s_axis_tlast on the
// final byte. master stream: one result beat per datagram, sent after its last byte.
// config port: i_cfg_addr 0 writes the first four transaction id bytes (i_cfg_wdata
// [31:0]), i_cfg_addr 1 the last eight; write only while no datagram is in flight.
// throughput: one byte per cycle unless a final byte waits for the result register, set
// by a single input register feeding the per-byte parse logic, which updates all datagram state per byte.
// the final byte passes the input register, then its result is captured in the result
// register, which offers the result beat on the master stream.
// reset (synchronous, active low) clears the transaction id, the datagram state
// and empties both pipeline registers.
// when the master side stalls, the block keeps taking bytes of the next datagram;
// it only holds s_axis_tready low when a final byte waits and the result
// register is still occupied.

module stun_binding_response_parser_core #(
    parameter int unsigned MAX_DATAGRAM_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [63:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_byte [7:0]
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // verdict [1:0], address_kind [3:2], mapped_address [35:4], zero fill [39:36]
    output logic [39:0] m_axis_tdata
);
    import stunp_pkg::*;

    logic    r_in_valid;
    t_beat   r_in_beat;
    logic    go;
    logic    out_free;
    logic    res_valid;
    t_result res;

    assign go            = r_in_valid && (!r_in_beat.last_byte || out_free);
    assign s_axis_tready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_beat <= '{data_byte: s_axis_tdata, last_byte: s_axis_tlast};
        end
    end

    stunp_parse #(
        .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_go        (go),
        .i_beat      (r_in_beat),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    stunp_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res_valid   (res_valid),
        .i_res         (res),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !res_valid)
        else $error("result produced while result register is held");

    a_held_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_beat.last_byte && !out_free) |=>
        (r_in_valid && r_in_beat.last_byte))
        else $error("waiting final byte lost");

endmodule
